>>> rtl/blwp_pkg.sv
// ----------------------------------------------------------------------------
// blwp_pkg
// Types and constants shared by the baseline/signal word packer.
// ----------------------------------------------------------------------------
package blwp_pkg;

  localparam int SAMPLE_W = 13;
  localparam int BL_W     = 6;
  localparam int WORD_W   = 32;
  localparam int BL_SLOTS = 5;
  localparam int SG_SLOTS = 2;

  // Word fragments, already shifted to their place in the word
  localparam logic [WORD_W-1:0] WORD_INIT  = 32'hF000_0000;
  localparam logic [WORD_W-1:0] CODE_BL5_W = 32'h4000_0000;  // code 01
  localparam logic [WORD_W-1:0] CODE_BLS_W = 32'h8000_0000;  // code 10
  localparam logic [WORD_W-1:0] CNT_ONE_W  = 32'h0100_0000;
  localparam logic [WORD_W-1:0] CNT_TWO_W  = 32'h0200_0000;
  localparam logic [WORD_W-1:0] CNT_THR_W  = 32'h0300_0000;
  localparam logic [WORD_W-1:0] CNT_FOUR_W = 32'h0400_0000;
  localparam logic [WORD_W-1:0] CODE_SG2_W = 32'h2800_0000;  // 0x0A in 31..26
  localparam logic [WORD_W-1:0] CODE_SG1_W = 32'h2C00_0000;  // 0x0B in 31..26
  localparam logic [WORD_W-1:0] SYNC_W     = 32'h0155_4000;  // 0xAAA in 25..13

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                is_baseline;
    logic                orbit_mark;
  } blwp_in_t;

  typedef struct packed {
    logic              word_valid;
    logic [WORD_W-1:0] packed_word;
  } blwp_out_t;

  typedef enum logic [24:0] {
    ST_IDLE     = 25'h000_0001,
    ST_BL0      = 25'h000_0002,
    ST_BL1      = 25'h000_0004,
    ST_BL2      = 25'h000_0008,
    ST_BL3      = 25'h000_0010,
    ST_BL4      = 25'h000_0020,
    ST_BLX0     = 25'h000_0040,
    ST_BLX1     = 25'h000_0080,
    ST_BLX2     = 25'h000_0100,
    ST_BLX3     = 25'h000_0200,
    ST_BLX4     = 25'h000_0400,
    ST_SG0      = 25'h000_0800,
    ST_SG1      = 25'h000_1000,
    ST_SGX0     = 25'h000_2000,
    ST_SGX1     = 25'h000_4000,
    ST_ORB0     = 25'h000_8000,
    ST_ORB1     = 25'h001_0000,
    ST_ORB2     = 25'h002_0000,
    ST_ORB3     = 25'h004_0000,
    ST_ORB4     = 25'h008_0000,
    ST_ORB_SIG  = 25'h010_0000,
    ST_ORB_SIGB = 25'h020_0000,
    ST_HDR      = 25'h040_0000,
    ST_HDR_SIG  = 25'h080_0000,
    ST_HDR_BL   = 25'h100_0000
  } pack_state_t;

endpackage

>>> rtl/blwp_in_reg.sv
// ----------------------------------------------------------------------------
// blwp_in_reg
// Input register stage: captures one sample word per cycle while the packer takes it.
// ----------------------------------------------------------------------------
module blwp_in_reg import blwp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  blwp_in_t in_data,
  output logic     st_valid,
  input  logic     st_ready,
  output blwp_in_t st_data
);

  logic     vld_r;
  blwp_in_t data_r;

  assign in_ready = !vld_r || st_ready;
  assign st_valid = vld_r;
  assign st_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

>>> rtl/blwp_pack.sv
// ----------------------------------------------------------------------------
// blwp_pack
// Packing state machine, sample slots and the result register.
// ----------------------------------------------------------------------------
module blwp_pack import blwp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      st_valid,
  output logic      st_ready,
  input  blwp_in_t  st_data,
  output logic      out_valid,
  input  logic      out_ready,
  output blwp_out_t out_data
);

  pack_state_t       state_r, state_nxt;
  logic [BL_W-1:0]   bl_slot_r  [BL_SLOTS];
  logic [BL_W-1:0]   bl_slot_nxt[BL_SLOTS];
  logic [SAMPLE_W-1:0] sg_slot_r  [SG_SLOTS];
  logic [SAMPLE_W-1:0] sg_slot_nxt[SG_SLOTS];
  logic              flag_r, flag_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              out_valid_r;
  logic              adv;
  logic              b, o, bo, so;
  logic [BL_W-1:0]   s6;
  logic [WORD_W-1:0] five_word, pair_word;

  assign st_ready  = !out_valid_r || out_ready;
  assign adv       = st_valid && st_ready;
  assign out_valid = out_valid_r;
  assign out_data  = '{word_valid: flag_r, packed_word: word_r};

  assign b  = st_data.is_baseline;
  assign o  = st_data.orbit_mark;
  assign bo = b && !o;
  assign so = !b && !o;
  assign s6 = st_data.sample[BL_W-1:0];

  assign five_word = CODE_BL5_W | {2'b00, bl_slot_r[4], bl_slot_r[3], bl_slot_r[2],
                                   bl_slot_r[1], bl_slot_r[0]};
  assign pair_word = CODE_SG2_W | {6'd0, sg_slot_r[1], sg_slot_r[0]};

  always_comb begin
    case (state_r)
      ST_IDLE:  state_nxt = bo ? ST_BL0 : (o ? ST_HDR  : ST_SG0);
      ST_BL0:   state_nxt = bo ? ST_BL1 : (o ? ST_ORB1 : ST_BLX1);
      ST_BL1:   state_nxt = bo ? ST_BL2 : (o ? ST_ORB2 : ST_BLX2);
      ST_BL2:   state_nxt = bo ? ST_BL3 : (o ? ST_ORB3 : ST_BLX3);
      ST_BL3:   state_nxt = bo ? ST_BL4 : (o ? ST_ORB4 : ST_BLX4);
      ST_BL4:   state_nxt = bo ? ST_BL0 : (o ? ST_ORB0 : ST_BLX0);
      ST_BLX0, ST_BLX1, ST_BLX2, ST_BLX3, ST_BLX4: begin
        state_nxt = bo ? ST_SGX0 : (o ? ST_ORB_SIGB : ST_SG0);
      end
      ST_SGX0, ST_SGX1: state_nxt = so ? ST_BLX0 : (o ? ST_ORB0 : ST_BL0);
      ST_SG0:   state_nxt = so ? ST_SG1 : (o ? ST_ORB_SIG  : ST_SGX1);
      ST_SG1:   state_nxt = so ? ST_SG0 : (o ? ST_ORB_SIGB : ST_SGX0);
      ST_ORB0, ST_ORB1, ST_ORB2, ST_ORB3, ST_ORB4, ST_ORB_SIGB: begin
        state_nxt = b ? ST_HDR_BL : ST_HDR_SIG;
      end
      ST_ORB_SIG: state_nxt = ST_HDR;
      ST_HDR:     state_nxt = b ? ST_BL0  : ST_SG0;
      ST_HDR_SIG: state_nxt = b ? ST_SGX0 : ST_SG0;
      ST_HDR_BL:  state_nxt = b ? ST_BL0  : ST_BLX0;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    bl_slot_nxt = bl_slot_r;
    sg_slot_nxt = sg_slot_r;
    flag_nxt    = flag_r;
    word_nxt    = word_r;
    case (state_r)
      ST_IDLE: begin
        flag_nxt = 1'b0;
        word_nxt = WORD_INIT;
      end
      ST_BL0: begin
        flag_nxt = 1'b0;
        bl_slot_nxt[1] = s6;
      end
      ST_BL1: begin
        flag_nxt = 1'b0;
        bl_slot_nxt[2] = s6;
      end
      ST_BL2: begin
        flag_nxt = 1'b0;
        bl_slot_nxt[3] = s6;
      end
      ST_BL3: begin
        flag_nxt = 1'b0;
        bl_slot_nxt[4] = s6;
      end
      ST_BL4: begin
        flag_nxt = 1'b1;
        word_nxt = five_word;
        bl_slot_nxt[0] = s6;
      end
      // short baseline words: count pattern marks how many slots are used; ST_BLX4 sends the five-slot word
      ST_BLX0: begin
        flag_nxt = 1'b1;
        word_nxt = CODE_BLS_W | CNT_ONE_W | {26'd0, bl_slot_r[0]};
        sg_slot_nxt[0] = st_data.sample;
      end
      ST_BLX1: begin
        flag_nxt = 1'b1;
        word_nxt = CODE_BLS_W | CNT_TWO_W | {20'd0, bl_slot_r[1], bl_slot_r[0]};
        sg_slot_nxt[0] = st_data.sample;
      end
      ST_BLX2: begin
        flag_nxt = 1'b1;
        word_nxt = CODE_BLS_W | CNT_THR_W |
                   {14'd0, bl_slot_r[2], bl_slot_r[1], bl_slot_r[0]};
        sg_slot_nxt[0] = st_data.sample;
      end
      ST_BLX3: begin
        flag_nxt = 1'b1;
        word_nxt = CODE_BLS_W | CNT_FOUR_W |
                   {8'd0, bl_slot_r[3], bl_slot_r[2], bl_slot_r[1], bl_slot_r[0]};
        sg_slot_nxt[0] = st_data.sample;
      end
      ST_BLX4: begin
        flag_nxt = 1'b1;
        word_nxt = five_word;
        sg_slot_nxt[0] = st_data.sample;
      end
      ST_SG0: begin
        flag_nxt = 1'b0;
        sg_slot_nxt[1] = st_data.sample;
      end
      ST_SGX0: begin
        flag_nxt = 1'b1;
        word_nxt = CODE_SG1_W | SYNC_W | {19'd0, sg_slot_r[0]};
        bl_slot_nxt[0] = s6;
      end
      ST_SG1: begin
        flag_nxt = 1'b1;
        word_nxt = pair_word;
        sg_slot_nxt[0] = st_data.sample;
      end
      ST_SGX1: begin
        flag_nxt = 1'b1;
        word_nxt = pair_word;
        bl_slot_nxt[0] = s6;
      end
      default: begin
        // orbit and header states leave the word untouched
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bl_slot_r   <= '{default: '0};
      sg_slot_r   <= '{default: '0};
      flag_r      <= 1'b0;
      word_r      <= WORD_INIT;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      state_r     <= state_nxt;
      bl_slot_r   <= bl_slot_nxt;
      sg_slot_r   <= sg_slot_nxt;
      flag_r      <= flag_nxt;
      word_r      <= word_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

>>> rtl/baseline_signal_word_packer_top.sv
// ----------------------------------------------------------------------------
// baseline_signal_word_packer_top
// Packs baseline and signal samples into 32-bit words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one word per cycle while in_ready is high: a
// 13-bit sample, a baseline flag and an orbit mark. The result channel
// (out_valid/out_ready/out_data) gives exactly one word per input: the
// load flag and the packed word register as they stand after that sample.
// Orbit and header states leave both fields as they were.
// The sample passes through the input register, then the packer state and
// result register, before out_valid rises. Throughput: one sample per cycle
// while the receiver keeps out_ready high, limited only by the single state
// update per sample.
// Reset (rst_n low, synchronous) empties both stages, puts the machine in
// idle, clears all slots and the load flag, and sets the word to F0000000.
// When the receiver stalls, the result holds on out_data, the input register
// fills, and in_ready drops once both stages are full; nothing is dropped.
// ----------------------------------------------------------------------------
module baseline_signal_word_packer_top import blwp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  blwp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output blwp_out_t out_data
);

  logic     st_valid;
  logic     st_ready;
  blwp_in_t st_data;

  blwp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .st_data  (st_data)
  );

  blwp_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_valid  (st_valid),
    .st_ready  (st_ready),
    .st_data   (st_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/blwp_checker.sv
// ----------------------------------------------------------------------------
// blwp_checker
// Port-level checks on the word packer, bound to the top level.
// ----------------------------------------------------------------------------
module blwp_checker import blwp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input blwp_out_t out_data
);

  // every accepted sample has a result on the port after the input register and the result register
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted sample produced no result");

  // with no result pending the pipeline must take input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with result side empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind baseline_signal_word_packer_top blwp_checker u_blwp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
